@@ hw/rtl/fsc_pkg.sv @@
// Shared types, constants and helper functions of the frustum sphere cull block.
package fsc_pkg;

  localparam int NUM_PLANES    = 6;
  localparam int NUM_COEF      = NUM_PLANES * 4;
  localparam int NUM_REGS      = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH        = 4;
  localparam int QCW           = $clog2(QDEPTH + 1);

  typedef logic signed [31:0] coef_t;
  typedef coef_t [NUM_COEF-1:0] coef_arr_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } item_t;

  typedef struct packed {
    logic           full;
    logic           valid;
    logic [QCW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } pg_stat_t;

  // Matrix row that each plane combines with row 3 (right, left, down, up, far, near)
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // Plane takes row 3 minus the other row when set, the sum otherwise
  function automatic logic plane_neg(input logic [2:0] p);
    logic n;
    case (p)
      3'd0, 3'd3, 3'd4: n = 1'b1;
      default:          n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/fsc_plane_gen.sv @@
// Matrix registers and the sequencer that derives and normalizes the six clip planes.
module fsc_plane_gen #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output fsc_pkg::pg_stat_t  stat,
  output fsc_pkg::coef_arr_t coef
);
  import fsc_pkg::*;

  localparam int NW = 34 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_STORE = 3'd6;

  logic [127:0]   mat_r [4];
  logic [2:0]     state_r;
  logic [2:0]     p_r;
  logic [1:0]     j_r;
  logic [CW-1:0]  cnt_r;
  logic [67:0]    sum_r;
  logic [67:0]    rad_r;
  logic [35:0]    rem_r;
  logic [33:0]    root_r;
  logic [33:0]    div_r;
  logic [NW-1:0]  num_r;
  logic [33:0]    drem_r;
  coef_t          coef_r [NUM_COEF];

  logic [127:0]       col_w;
  logic [1:0]         row_w;
  logic signed [32:0] base_w;
  logic signed [32:0] other_w;
  logic signed [32:0] raw_w;
  logic [32:0]        mag_w;
  logic [65:0]        sq_w;
  logic [67:0]        sum_nxt;
  logic [37:0]        srem_w;
  logic [37:0]        trial_w;
  logic               sge_w;
  logic [35:0]        rem_nxt;
  logic [33:0]        root_nxt;
  logic [34:0]        drem_w;
  logic               dge_w;
  logic [33:0]        drem_nxt;
  coef_t              sat_w;
  logic               cfg_hit;

  // Select the raw plane coefficient for the current plane and column
  always_comb begin
    col_w   = mat_r[j_r];
    row_w   = plane_row(p_r);
    base_w  = {col_w[127], col_w[127:96]};
    other_w = {col_w[32*row_w+31], col_w[32*row_w +: 32]};
    raw_w   = plane_neg(p_r) ? (base_w - other_w) : (base_w + other_w);
    mag_w   = raw_w[32] ? 33'(-raw_w) : 33'(raw_w);
    sq_w    = {33'b0, mag_w} * {33'b0, mag_w};
    sum_nxt = sum_r + 68'(sq_w);
  end

  // One digit of the integer square root
  always_comb begin
    srem_w   = {rem_r, rad_r[67:66]};
    trial_w  = {2'b00, root_r, 2'b01};
    sge_w    = (srem_w >= trial_w);
    rem_nxt  = sge_w ? 36'(srem_w - trial_w) : srem_w[35:0];
    root_nxt = {root_r[32:0], sge_w};
  end

  // One bit of the restoring divide
  always_comb begin
    drem_w   = {drem_r, num_r[NW-1]};
    dge_w    = (drem_w >= {1'b0, div_r});
    drem_nxt = dge_w ? 34'(drem_w - {1'b0, div_r}) : drem_w[33:0];
  end

  // Saturate the quotient to a signed 32-bit coefficient
  always_comb begin
    if (raw_w[32]) begin
      if (num_r > NW'(33'h0_8000_0000)) sat_w = 32'sh8000_0000;
      else sat_w = coef_t'(-num_r[31:0]);
    end else begin
      if (num_r > NW'(33'h0_7FFF_FFFF)) sat_w = 32'sh7FFF_FFFF;
      else sat_w = coef_t'(num_r[31:0]);
    end
  end

  assign cfg_hit   = cfg_valid && (state_r == ST_IDLE) && (cfg_index < 4'(NUM_REGS));
  assign stat.busy = (state_r != ST_IDLE);

  // Matrix registers: reset to identity, one half column per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 4; c++) mat_r[c] <= 128'(1) << (16 + 32 * c);
    end else if (cfg_hit) begin
      if (cfg_index[0]) mat_r[cfg_index[2:1]][127:64] <= cfg_data;
      else mat_r[cfg_index[2:1]][63:0] <= cfg_data;
    end
  end

  // Plane sequencer: squares, root (when the sum is not zero), four divides per plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      p_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_hit) begin
            state_r <= ST_START;
            p_r     <= '0;
          end
        end
        ST_START: begin
          sum_r   <= '0;
          j_r     <= '0;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          sum_r <= sum_nxt;
          if (j_r == 2'd2) begin
            j_r <= '0;
            if (sum_nxt == '0) begin
              div_r   <= 34'd65536;
              state_r <= ST_LOAD;
            end else begin
              rad_r   <= sum_nxt;
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= '0;
              state_r <= ST_ROOT;
            end
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        ST_ROOT: begin
          rad_r  <= {rad_r[65:0], 2'b00};
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(33)) begin
            div_r   <= root_nxt;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          num_r   <= NW'({mag_w, {FRAC_BITS{1'b0}}}) + NW'(div_r >> 1);
          drem_r  <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          drem_r <= drem_nxt;
          num_r  <= {num_r[NW-2:0], dge_w};
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(NW - 1)) state_r <= ST_STORE;
        end
        ST_STORE: begin
          coef_r[{p_r, j_r}] <= sat_w;
          if (j_r == 2'd3) begin
            if (p_r == 3'(NUM_PLANES - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              p_r     <= p_r + 3'd1;
              state_r <= ST_START;
            end
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Present the plane table
  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) coef[i] = coef_r[i];
  end

endmodule

@@ hw/rtl/fsc_queue.sv @@
// Short queue of accepted spheres between the front and the test pipeline.
module fsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fsc_pkg::item_t   push_item,
  input  logic             pop,
  output fsc_pkg::item_t   head_item,
  output fsc_pkg::q_stat_t stat
);
  import fsc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  item_t          slot_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == QCW'(QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCW'(1);
    else if (!push && pop) count_nxt = count_r - QCW'(1);
  end

  // Store a transfer at the tail
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/fsc_test.sv @@
// Pipelined sphere-against-six-planes test with a registered result.
module fsc_test #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsc_pkg::coef_arr_t coef,
  input  logic               q_valid,
  input  fsc_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_inside_res
);
  import fsc_pkg::*;

  localparam int SUMW = 68;

  logic signed [63:0]     prod_r [NUM_PLANES][3];
  logic signed [SUMW-1:0] dr_r   [NUM_PLANES];
  logic                   s1_valid_r;
  logic                   out_valid_r;
  logic                   inside_r;
  logic                   adv;
  logic [NUM_PLANES-1:0]  pass_w;

  assign adv            = !out_valid_r || !out_stall;
  assign q_pop          = q_valid && adv;
  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

  // Multiply centre by plane normals, form offset and radius terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        prod_r[p][0] <= $signed(q_item.center_x) * $signed(coef[4*p]);
        prod_r[p][1] <= $signed(q_item.center_y) * $signed(coef[4*p+1]);
        prod_r[p][2] <= $signed(q_item.center_z) * $signed(coef[4*p+2]);
        dr_r[p]      <= ($signed({{(SUMW-32){coef[4*p+3][31]}}, coef[4*p+3]}) <<< 16)
                      + $signed({{(SUMW-31){1'b0}}, q_item.radius} << FRAC_BITS);
      end
    end
  end

  // Sum per plane and check the positive side
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      pass_w[p] = (SUMW'(prod_r[p][0]) + SUMW'(prod_r[p][1]) + SUMW'(prod_r[p][2])
                   + dr_r[p]) > $signed(SUMW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) inside_r <= &pass_w;
  end

  // Advance the valid bits, hold while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      out_valid_r <= s1_valid_r;
    end
  end

endmodule

@@ hw/rtl/frustum_sphere_cull.sv @@
// Top level of the frustum sphere cull block: plane generator, queue and test pipeline.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_center_x, in_center_y, in_center_z, in_radius
//  out     | output    | out_valid / out_stall| out_inside_res
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sphere per cycle while neither in_stall nor out_stall holds; a result is registered in
// the queue, the product registers and the result register before it is offered.
// The 18 signed 32x32 multipliers and one add-and-compare per plane set that rate.
// After reset and after each matrix write the plane sequencer runs; in_stall and !cfg_ready
// hold meanwhile.
// A stalled output holds the test pipeline; the four-entry queue keeps taking spheres until it is full.
module frustum_sphere_cull #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_center_x,
  input  logic [31:0] in_center_y,
  input  logic [31:0] in_center_z,
  input  logic [30:0] in_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fsc_pkg::*;

  pg_stat_t  pg_stat;
  q_stat_t   q_stat;
  coef_arr_t coef;
  item_t     in_item;
  item_t     head_item;
  logic      push;
  logic      pop;

  assign cfg_ready = !pg_stat.busy;
  assign in_stall  = pg_stat.busy || q_stat.full;
  assign push      = in_valid && !in_stall;

  assign in_item.center_x = in_center_x;
  assign in_item.center_y = in_center_y;
  assign in_item.center_z = in_center_z;
  assign in_item.radius   = in_radius;

  fsc_plane_gen #(.FRAC_BITS(FRAC_BITS)) u_plane_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (pg_stat),
    .coef      (coef)
  );

  fsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  fsc_test #(.FRAC_BITS(FRAC_BITS)) u_test (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef),
    .q_valid        (q_stat.valid),
    .q_item         (head_item),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res)
  );

  // A matrix transfer starts a plane update
  a_cfg_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index < 4'(NUM_REGS))) |=> !cfg_ready)
    else $error("matrix write did not start plane update");

  // An accepted sphere lands in the queue
  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (q_stat.count != '0))
    else $error("accepted sphere missing from queue");

endmodule
